>>> hdl/adfe_pkg.sv
`timescale 1ns / 1ps

package adfe_pkg;

  localparam int          BUF_DEPTH_DEF = 64;
  localparam int          MARK_LEN      = 5;
  localparam logic [6:0]  OUT_ROOM_RST  = 7'd64;
  localparam logic [15:0] LEN_MAX       = 16'hFFFF;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  progress;
    logic        marker_seen;
    logic [15:0] length;
    logic        digits_open;
    logic        colon_seen;
    logic        blind;
  } scan_t;

  localparam scan_t SCAN_RST = '{
    progress:    3'd0,
    marker_seen: 1'b0,
    length:      16'd0,
    digits_open: 1'b1,
    colon_seen:  1'b0,
    blind:       1'b0
  };

  function automatic logic [7:0] mark_char(input logic [2:0] idx);
    case (idx)
      3'd0:    mark_char = 8'h2B;
      3'd1:    mark_char = 8'h49;
      3'd2:    mark_char = 8'h50;
      3'd3:    mark_char = 8'h44;
      3'd4:    mark_char = 8'h2C;
      default: mark_char = 8'h2B;
    endcase
  endfunction

endpackage

>>> hdl/adfe_rx_if.sv
`timescale 1ns / 1ps

interface adfe_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

>>> hdl/adfe_out_if.sv
`timescale 1ns / 1ps

interface adfe_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        has_data;
  logic        last;
  logic [15:0] declared_length;

  modport source(output valid, output payload_byte, output has_data, output last,
                 output declared_length, input ready);
  modport sink(input valid, input payload_byte, input has_data, input last,
               input declared_length, output ready);
endinterface

>>> hdl/adfe_ram.sv
`timescale 1ns / 1ps

module adfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/at_data_frame_extractor.sv
`timescale 1ns / 1ps
// Channel   Dir  Beat payload
// rx        in   rx_byte
// res       out  payload_byte, has_data, last, declared_length
// cfg       in   cfg_data (out_room), written when cfg_we is high
//
// A received byte is written to the line memory; if the memory is full, the
// line is dropped and parsing restarts. When a message completes, the memory
// is walked from the byte after the colon through the single read port with
// its registered output. No byte is accepted during the walk; a stalled result
// stage holds the walk. Synchronous reset clears the parse state.

module at_data_frame_extractor
  import adfe_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  adfe_rx_if.sink           rx,
  adfe_out_if.source        res,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data
);

  localparam int            CW   = $clog2(BUF_DEPTH);
  localparam logic [CW-1:0] FULL = CW'(BUF_DEPTH - 1);

  seq_state_t    state, state_next;
  logic [6:0]    out_room;
  logic [CW-1:0] fill;
  scan_t         scan, scan_next;
  logic [CW-1:0] colon_idx;
  logic [CW-1:0] idx;
  logic [6:0]    cnt;
  logic          pend_valid;
  logic [7:0]    pend_byte;

  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_has;
  logic          out_last;
  logic [15:0]   out_len;

  logic          rx_fire;
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    rd_data;
  logic          colon_hit;
  logic          done;
  logic [CW-1:0] colon_pos;
  logic [CW-1:0] received;
  logic [19:0]   len_mul;
  logic [6:0]    room;
  logic          slot_free;
  logic          end_walk;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_has;
  logic          emit_last;
  logic          take;
  logic          finish;

  assign rx_fire   = rx.valid && rx.ready;
  assign room      = (out_room == 7'd0) ? 7'd0 : out_room - 7'd1;
  assign slot_free = !out_valid || res.ready;

  assign res.valid           = out_valid;
  assign res.payload_byte    = out_byte;
  assign res.has_data        = out_has;
  assign res.last            = out_last;
  assign res.declared_length = out_len;

  adfe_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill),
    .wdata(rx.rx_byte),
    .re   (ram_re),
    .raddr(idx),
    .rdata(rd_data)
  );

  always_comb begin
    scan_next = scan;
    colon_hit = 1'b0;
    len_mul   = ({4'd0, scan.length} << 3) + ({4'd0, scan.length} << 1)
              + 20'(rx.rx_byte - CH_ZERO);
    if (!scan.blind && !scan.colon_seen) begin
      if (!scan.marker_seen) begin
        if (rx.rx_byte == CH_NUL) begin
          scan_next.blind    = 1'b1;
          scan_next.progress = 3'd0;
        end else if (rx.rx_byte == mark_char(scan.progress)) begin
          if (scan.progress == 3'(MARK_LEN - 1)) begin
            scan_next.marker_seen = 1'b1;
            scan_next.progress    = 3'd0;
            scan_next.length      = 16'd0;
            scan_next.digits_open = 1'b1;
          end else begin
            scan_next.progress = scan.progress + 3'd1;
          end
        end else begin
          scan_next.progress = (rx.rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
        end
      end else if (rx.rx_byte == CH_NUL) begin
        scan_next.blind       = 1'b1;
        scan_next.digits_open = 1'b0;
      end else if (scan.digits_open && rx.rx_byte >= CH_ZERO && rx.rx_byte <= CH_NINE) begin
        scan_next.length = (len_mul > {4'd0, LEN_MAX}) ? LEN_MAX : len_mul[15:0];
      end else begin
        scan_next.digits_open = 1'b0;
        if (rx.rx_byte == CH_COLON) begin
          scan_next.colon_seen = 1'b1;
          colon_hit            = 1'b1;
        end
      end
    end
    colon_pos = colon_hit ? fill : colon_idx;
    received  = fill - colon_pos;
    done      = scan_next.colon_seen && (16'(received) >= scan_next.length);
  end

  always_comb begin
    state_next = state;
    rx.ready   = (state == S_IDLE);
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    end_walk   = (idx >= fill) || (cnt >= room) || (rd_data == CH_NUL);
    emit       = 1'b0;
    emit_byte  = pend_byte;
    emit_has   = 1'b1;
    emit_last  = 1'b0;
    take       = 1'b0;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (rx_fire && fill != FULL) begin
          ram_we = 1'b1;
          if (done) begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (end_walk) begin
          if (slot_free) begin
            emit       = 1'b1;
            emit_byte  = pend_valid ? pend_byte : 8'd0;
            emit_has   = pend_valid;
            emit_last  = 1'b1;
            finish     = 1'b1;
            state_next = S_IDLE;
          end
        end else if (!pend_valid) begin
          take       = 1'b1;
          state_next = S_READ;
        end else if (slot_free) begin
          emit       = 1'b1;
          take       = 1'b1;
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_room   <= OUT_ROOM_RST;
      fill       <= '0;
      scan       <= SCAN_RST;
      colon_idx  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      cnt        <= 7'd0;
    end else begin
      if (cfg_we) begin
        out_room <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_byte  <= emit_byte;
        out_has   <= emit_has;
        out_last  <= emit_last;
        out_len   <= scan.length;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (rx_fire) begin
        if (fill == FULL) begin
          fill      <= '0;
          scan      <= SCAN_RST;
          colon_idx <= '0;
        end else begin
          fill      <= fill + CW'(1);
          scan      <= scan_next;
          colon_idx <= colon_pos;
          if (done) begin
            idx        <= colon_pos + CW'(1);
            cnt        <= 7'd0;
            pend_valid <= 1'b0;
          end
        end
      end
      if (take) begin
        pend_byte  <= rd_data;
        pend_valid <= 1'b1;
        cnt        <= cnt + 7'd1;
        idx        <= idx + CW'(1);
      end
      if (finish) begin
        fill       <= '0;
        scan       <= SCAN_RST;
        colon_idx  <= '0;
        pend_valid <= 1'b0;
      end
    end
  end

endmodule
